FILE: sv/modexp_pkg.sv
package modexp_pkg;

    // defaults for the top-level parameters
    localparam int WIDTH_DEF     = 32;
    localparam int EXP_WIDTH_DEF = 64;

    // fixed field widths
    localparam int BASE_W  = 64;
    localparam int EXPIN_W = 64;
    localparam int OUT_W   = 32;
    localparam int CFG_W   = 32;
    localparam int PADDR_W = 3;

    // reduction step counter, holds up to BASE_W
    localparam int STEP_W = $clog2(BASE_W + 1);

    // register map
    localparam logic [31:0] RESET_MODULUS = 32'd23;
    localparam logic [0:0]  REG_MODULUS   = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE_START,
        ST_BASE_WAIT,
        ST_MUL,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_item;
        logic start_base;
        logic update_base;
        logic start_mul;
        logic update_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic red_done;
        logic exp_zero;
    } status_t;

endpackage

FILE: sv/modexp_reduce.sv
module modexp_reduce #(
    parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [modexp_pkg::BASE_W-1:0]  dividend,
    input  logic [modexp_pkg::STEP_W-1:0]  steps,
    input  logic [WIDTH:0]                 modulus_ext,
    output logic                           done,
    output logic [WIDTH-1:0]               remainder
);

    logic [modexp_pkg::BASE_W-1:0] div_reg, div_next;
    logic [modexp_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0]              rem_reg, rem_next;
    logic [WIDTH:0]                trial;
    logic [WIDTH:0]                diff;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, div_reg[modexp_pkg::BASE_W-1]};
        diff     = trial - modulus_ext;
        div_next = div_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        if (start)
        begin
            div_next = dividend;
            cnt_next = steps;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            div_next = div_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (trial >= modulus_ext)
            begin
                rem_next = diff[WIDTH-1:0];
            end
            else
            begin
                rem_next = trial[WIDTH-1:0];
            end
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // shift and remainder registers
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = (cnt_reg == '0);
    assign remainder = rem_reg;

endmodule

FILE: sv/modexp_datapath.sv
module modexp_datapath #(
    parameter int WIDTH     = modexp_pkg::WIDTH_DEF,
    parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  modexp_pkg::cmd_t              cmd,
    output modexp_pkg::status_t           status,
    input  logic [modexp_pkg::BASE_W-1:0] base_value,
    input  logic [EXP_WIDTH-1:0]          exponent,
    input  logic [WIDTH-1:0]              modulus,
    output logic [WIDTH-1:0]              result
);

    localparam int PROD_W = 2 * WIDTH;

    logic [WIDTH-1:0]     acc_reg, acc_next;
    logic [WIDTH-1:0]     sq_reg, sq_next;
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;
    logic [PROD_W-1:0]    prod_a_reg, prod_s_reg;
    logic [WIDTH-1:0]     result_reg;
    logic [WIDTH:0]       modulus_ext;

    logic [modexp_pkg::BASE_W-1:0] base_reg, base_next;
    logic [modexp_pkg::BASE_W-1:0] div_a, div_b;
    logic [modexp_pkg::STEP_W-1:0] steps_a;
    logic                          start_a;
    logic                          done_a, done_b;
    logic [WIDTH-1:0]              rem_a, rem_b;

    // a zero modulus reduces modulo 2^WIDTH
    assign modulus_ext = (modulus == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, modulus};

    // products left-aligned in the reduction shift register
    assign div_a   = cmd.start_base ? base_reg
                   : (modexp_pkg::BASE_W'(prod_a_reg) << (modexp_pkg::BASE_W - PROD_W));
    assign div_b   = modexp_pkg::BASE_W'(prod_s_reg) << (modexp_pkg::BASE_W - PROD_W);
    assign steps_a = cmd.start_base ? modexp_pkg::STEP_W'(modexp_pkg::BASE_W)
                   : modexp_pkg::STEP_W'(PROD_W);
    assign start_a = cmd.start_base | (cmd.start_mul & exp_reg[0]);

    // running-result reduction, also used for the base
    modexp_reduce #(
        .WIDTH (WIDTH)
    ) u_red_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start_a),
        .dividend    (div_a),
        .steps       (steps_a),
        .modulus_ext (modulus_ext),
        .done        (done_a),
        .remainder   (rem_a)
    );

    // square reduction
    modexp_reduce #(
        .WIDTH (WIDTH)
    ) u_red_sq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.start_mul),
        .dividend    (div_b),
        .steps       (modexp_pkg::STEP_W'(PROD_W)),
        .modulus_ext (modulus_ext),
        .done        (done_b),
        .remainder   (rem_b)
    );

    // operand updates
    always_comb
    begin
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        exp_next  = exp_reg;
        base_next = base_reg;
        if (cmd.load_item)
        begin
            acc_next  = WIDTH'(1);
            exp_next  = exponent;
            base_next = base_value;
        end
        else if (cmd.update_base)
        begin
            sq_next = rem_a;
        end
        else if (cmd.update_step)
        begin
            if (exp_reg[0])
            begin
                acc_next = rem_a;
            end
            sq_next  = rem_b;
            exp_next = exp_reg >> 1;
        end
    end

    // operand, product and result registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_reg    <= exp_next;
        base_reg   <= base_next;
        prod_a_reg <= PROD_W'(acc_reg) * PROD_W'(sq_reg);
        prod_s_reg <= PROD_W'(sq_reg) * PROD_W'(sq_reg);
        if (cmd.load_out)
        begin
            result_reg <= acc_reg;
        end
    end

    assign status.red_done = done_a & done_b;
    assign status.exp_zero = (exp_reg == '0);
    assign result          = result_reg;

endmodule

FILE: sv/modexp_ctrl.sv
module modexp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  modexp_pkg::status_t status,
    output modexp_pkg::cmd_t    cmd
);

    modexp_pkg::state_t state_reg, state_next;
    logic               out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = modexp_pkg::ST_BASE_START;
                end
            end
            modexp_pkg::ST_BASE_START:
            begin
                cmd.start_base = 1'b1;
                state_next     = modexp_pkg::ST_BASE_WAIT;
            end
            modexp_pkg::ST_BASE_WAIT:
            begin
                if (status.red_done)
                begin
                    cmd.update_base = 1'b1;
                    state_next      = modexp_pkg::ST_MUL;
                end
            end
            modexp_pkg::ST_MUL:
            begin
                if (status.exp_zero)
                begin
                    state_next = modexp_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = modexp_pkg::ST_MUL_START;
                end
            end
            modexp_pkg::ST_MUL_START:
            begin
                cmd.start_mul = 1'b1;
                state_next    = modexp_pkg::ST_MUL_WAIT;
            end
            modexp_pkg::ST_MUL_WAIT:
            begin
                if (status.red_done)
                begin
                    cmd.update_step = 1'b1;
                    state_next      = modexp_pkg::ST_MUL;
                end
            end
            modexp_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = modexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    // output item valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= modexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/modular_exponentiation.sv
// throughput: one item at a time, the input opens again in the same cycle as the result appears;
// each exponent bit costs one restoring reduction of 2*WIDTH steps, the square always and the
// multiply for a set bit, in parallel; the base reduction takes 64 steps
// reset: asynchronous active low, modulus back to 23, no item held
module modular_exponentiation #(
    parameter int WIDTH     = modexp_pkg::WIDTH_DEF,
    parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [127:0]                   s_tdata,   // base_value, exponent
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [modexp_pkg::OUT_W-1:0]   m_tdata,   // power_result
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [modexp_pkg::PADDR_W-1:0] paddr,
    input  logic [modexp_pkg::CFG_W-1:0]   pwdata,
    output logic [modexp_pkg::CFG_W-1:0]   prdata,
    output logic                           pready
);

    modexp_pkg::cmd_t    cmd;
    modexp_pkg::status_t status;
    logic [WIDTH-1:0]    modulus_reg;
    logic [WIDTH-1:0]    result;
    logic                cfg_write;

    // configuration register
    assign cfg_write = psel & penable & pwrite & (paddr[2] == modexp_pkg::REG_MODULUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= modexp_pkg::RESET_MODULUS[WIDTH-1:0];
        end
        else if (cfg_write)
        begin
            modulus_reg <= pwdata[WIDTH-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == modexp_pkg::REG_MODULUS)
                  ? modexp_pkg::CFG_W'(modulus_reg) : '0;

    // sequencer
    modexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // operands, multipliers and reductions
    modexp_datapath #(
        .WIDTH     (WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .base_value (s_tdata[modexp_pkg::BASE_W-1:0]),
        .exponent   (s_tdata[modexp_pkg::BASE_W +: EXP_WIDTH]),
        .modulus    (modulus_reg),
        .result     (result)
    );

    assign m_tdata = modexp_pkg::OUT_W'(result);

endmodule

FILE: sv/modexp_checker.sv
module modexp_checker #(
    parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [modexp_pkg::OUT_W-1:0]   m_tdata,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [modexp_pkg::PADDR_W-1:0] paddr,
    input logic [modexp_pkg::CFG_W-1:0]   pwdata,
    input logic [modexp_pkg::CFG_W-1:0]   prdata,
    input logic                           pready
);

    // an accepted item keeps the input closed while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input open right after an accepted item");

    // a new result only appears while the input is closed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without an item in work");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

    // a modulus write reads back at its kept width
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == '0)
        |=> (prdata == modexp_pkg::CFG_W'($past(pwdata[WIDTH-1:0])) || paddr != '0))
    else $error("modulus read-back mismatch");

endmodule

bind modular_exponentiation modexp_checker #(.WIDTH(WIDTH)) u_modexp_checker (.*);

FILE: dv/power_checker.sv
module power_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [127:0]                   s_tdata,   // base_value, exponent
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [modexp_pkg::OUT_W-1:0]   m_tdata,   // power_result
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [modexp_pkg::PADDR_W-1:0] paddr,
    input  logic [modexp_pkg::CFG_W-1:0]   pwdata,
    input  logic [modexp_pkg::CFG_W-1:0]   prdata,
    input  logic                           pready,
    output int                             pending,
    output int                             mismatches
);

    localparam logic [63:0] WIDTH_MASK = (64'd1 << modexp_pkg::WIDTH_DEF) - 64'd1;
    localparam logic [63:0] EXP_MASK   = {64{1'b1}} >> (64 - modexp_pkg::EXP_WIDTH_DEF);

    logic [modexp_pkg::CFG_W-1:0] modulus_q;
    logic [modexp_pkg::OUT_W-1:0] powers_due[$];

    // a zero modulus wraps at 2**WIDTH
    function automatic logic [63:0] fold(input logic [63:0] x,
                                         input logic [modexp_pkg::CFG_W-1:0] m);
        if (m == '0)
            return x & WIDTH_MASK;
        return x % {32'd0, m};
    endfunction

    // right-to-left square and multiply, every operand kept below 2**32
    function automatic logic [modexp_pkg::OUT_W-1:0] mod_power(
        input logic [63:0]                  base_v,
        input logic [63:0]                  exp_v,
        input logic [modexp_pkg::CFG_W-1:0] m);
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] e;
        sq  = fold(base_v, m);
        e   = exp_v & EXP_MASK;
        acc = 64'd1;
        while (e != 0) begin
            if (e[0])
                acc = fold(acc * sq, m);
            sq = fold(sq * sq, m);
            e  = e >> 1;
        end
        return acc[modexp_pkg::OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [modexp_pkg::OUT_W-1:0] due;
        int                           errs;
        if (!rst_n)
        begin
            modulus_q <= modexp_pkg::RESET_MODULUS & WIDTH_MASK[modexp_pkg::CFG_W-1:0];
            powers_due.delete();
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            errs = 0;
            // results first, so an item taken at the same edge queues behind
            if (m_tvalid && m_tready)
            begin
                if (powers_due.size() == 0)
                begin
                    $error("power_result %0h arrived with no item outstanding", m_tdata);
                    errs++;
                end
                else
                begin
                    due = powers_due.pop_front();
                    if (m_tdata !== due)
                    begin
                        $error("power_result mismatch: expected %0h, actual %0h", due, m_tdata);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                powers_due.push_back(mod_power(s_tdata[63:0], s_tdata[127:64], modulus_q));
            // read-back of the modulus register
            if (psel && penable && !pwrite && pready && paddr[2] == modexp_pkg::REG_MODULUS)
            begin
                if (prdata !== modulus_q)
                begin
                    $error("modulus mismatch: expected %0h, actual %0h", modulus_q, prdata);
                    errs++;
                end
            end
            // register write, other indexes are ignored
            if (psel && penable && pwrite && pready && paddr[2] == modexp_pkg::REG_MODULUS)
                modulus_q <= pwdata & WIDTH_MASK[modexp_pkg::CFG_W-1:0];
            mismatches <= mismatches + errs;
            pending    <= powers_due.size();
        end
    end

endmodule

FILE: dv/tb_modular_exponentiation.sv
module tb_modular_exponentiation;

    localparam logic [modexp_pkg::PADDR_W-1:0] MODULUS_ADDR  =
        {modexp_pkg::REG_MODULUS, 2'b00};
    localparam logic [modexp_pkg::PADDR_W-1:0] UNMAPPED_ADDR =
        {~modexp_pkg::REG_MODULUS, 2'b00};
    localparam logic [63:0]                    ALL_ONES      = {64{1'b1}};

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [127:0]                   s_tdata;   // base_value, exponent
    logic                           m_tvalid;
    logic                           m_tready;
    logic [modexp_pkg::OUT_W-1:0]   m_tdata;   // power_result
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [modexp_pkg::PADDR_W-1:0] paddr;
    logic [modexp_pkg::CFG_W-1:0]   pwdata;
    logic [modexp_pkg::CFG_W-1:0]   prdata;
    logic                           pready;

    int   pending;
    int   mismatches;
    int   burst_left;
    logic offering;
    logic hold_req;
    logic hold_done;

    modular_exponentiation u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    power_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pending    (pending),
        .mismatches (mismatches)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #25_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // offer one item, then maybe close the burst with a gap
    task automatic offer_item(input logic [63:0] base_v, input logic [63:0] exp_v);
        s_tdata  <= {exp_v, base_v};
        s_tvalid <= 1'b1;
        offering = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic drain_results();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // setup and access cycle, then the bus is left quiet
    task automatic apb_write(input logic [modexp_pkg::PADDR_W-1:0] addr,
                             input logic [modexp_pkg::CFG_W-1:0]   data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // read transfer, the checker compares the returned value
    task automatic apb_read(input logic [modexp_pkg::PADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // mostly full-width operands, short exponents keep the run time down
    task automatic random_item(input logic [modexp_pkg::CFG_W-1:0] m);
        logic [63:0] b;
        logic [63:0] e;
        int          pick;
        case ($urandom_range(0, 9))
            0:       b = '0;
            1:       b = ALL_ONES;
            2:       b = {32'd0, m};
            3:       b = {32'd0, m - 32'd1};
            default: b = {$urandom, $urandom};
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 8)
            e = {$urandom, $urandom};
        else if (pick < 17)
            e = {$urandom, $urandom} & ((64'd1 << $urandom_range(1, 12)) - 64'd1);
        else if (pick == 17)
            e = '0;
        else if (pick == 18)
            e = ALL_ONES;
        else
            e = 64'd1 << $urandom_range(0, 63);
        offer_item(b, e);
    endtask

    // result side: patterns of its own plus one long hold-off
    initial
    begin
        int mode;
        m_tready <= 1'b0;
        hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 300))
            begin
                @(posedge clk);
                if (hold_req && !hold_done)
                begin
                    hold_done = 1'b1;
                    m_tready <= 1'b0;
                    repeat (12000) @(posedge clk);
                end
                else
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= $urandom_range(0, 1);
                        default: m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [modexp_pkg::CFG_W-1:0] modulus_v;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        offering = 1'b0;
        hold_req = 1'b0;
        burst_left = $urandom_range(1, 8);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus of 23: zero operands, extremes, top exponent bit alone
        apb_read(MODULUS_ADDR);
        offer_item(64'd0, 64'd0);
        offer_item(64'd0, ALL_ONES);
        offer_item(ALL_ONES, ALL_ONES);
        offer_item(ALL_ONES, 64'd0);
        offer_item(64'd5, 64'd1);
        offer_item(64'd22, 64'd2);
        offer_item(64'd23, 64'd7);
        offer_item(64'd2, 64'd1 << 63);

        // modulus of one, zero exponent still gives one
        drain_results();
        apb_write(MODULUS_ADDR, 32'd1);
        apb_read(MODULUS_ADDR);
        offer_item({$urandom, $urandom}, 64'd0);
        offer_item(64'd7, 64'd3);

        // largest modulus
        drain_results();
        apb_write(MODULUS_ADDR, 32'hFFFF_FFFF);
        apb_read(MODULUS_ADDR);
        offer_item(ALL_ONES, ALL_ONES);
        offer_item(64'hFFFF_FFFE, 64'd2);
        offer_item(64'h1_0000_0000, 64'd5);

        // zero modulus, reductions become a mask
        drain_results();
        apb_write(MODULUS_ADDR, 32'd0);
        apb_read(MODULUS_ADDR);
        offer_item(ALL_ONES, 64'd1);
        offer_item(64'd3, 64'd40);
        offer_item({$urandom, $urandom}, 64'd0);
        offer_item(64'hFFFF_FFFF_0000_0002, 64'd33);

        // write to an unmapped address leaves the modulus alone
        drain_results();
        apb_write(UNMAPPED_ADDR, 32'd5);
        apb_read(MODULUS_ADDR);
        offer_item(64'd2, 64'd35);
        offer_item(64'd3, 64'd5);

        // smallest useful modulus
        drain_results();
        apb_write(MODULUS_ADDR, 32'd2);
        apb_read(MODULUS_ADDR);
        offer_item({$urandom, $urandom}, {$urandom, $urandom});

        // random phases, each with its own modulus
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       modulus_v = $urandom;
                1:       modulus_v = 32'hFFFF_FFFF;
                2:       modulus_v = $urandom_range(2, 1000);
                3:       modulus_v = 32'd3;
                4:       modulus_v = {1'b1, 31'($urandom)};
                default: modulus_v = $urandom_range(1, 65535);
            endcase
            if (modulus_v == '0)
                modulus_v = 32'd1;
            drain_results();
            apb_write(MODULUS_ADDR, modulus_v);
            apb_read(MODULUS_ADDR);
            if (ph == 0)
                hold_req = 1'b1;
            repeat (18) random_item(modulus_v);
        end

        drain_results();
        repeat (5000) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/modexp_pkg.sv
sv/modexp_reduce.sv
sv/modexp_datapath.sv
sv/modexp_ctrl.sv
sv/modular_exponentiation.sv
sv/modexp_checker.sv
dv/power_checker.sv
dv/tb_modular_exponentiation.sv
